/* hw/rtl/spmd_pkg.sv */
// Types and constants shared by the signal delivery controller.
package spmd_pkg;

  typedef enum logic [1:0] {
    OpRaise    = 2'd0,
    OpSetMask  = 2'd1,
    OpRegister = 2'd2,
    OpDeliver  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StInvalid    = 2'd1,
    StMaskDenied = 2'd2,
    StProtected  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    DispNone         = 3'd0,
    DispIgnored      = 3'd1,
    DispChildDefault = 3'd2,
    DispTerminate    = 3'd3,
    DispRunHandler   = 3'd4,
    DispNotDeliver   = 3'd5
  } disp_e;

  localparam logic [5:0]  SigKill        = 6'd9;
  localparam logic [5:0]  SigChild       = 6'd17;
  localparam logic [31:0] KillMask       = 32'h0000_0100;
  localparam logic [31:0] HandlerDefault = 32'h0000_0000;
  localparam logic [31:0] HandlerIgnore  = 32'h0000_0001;

  // Last field in the lowest bits.
  typedef struct packed {
    logic        target_waiting;
    logic        target_protected;
    logic        nomask_flag;
    logic        oneshot_flag;
    logic [31:0] action_mask;
    logic [31:0] restorer_addr;
    logic [31:0] handler_addr;
    logic [31:0] new_mask;
    logic [5:0]  sig_num;
  } in_item_t;

  typedef struct packed {
    logic        old_nomask;
    logic        old_oneshot;
    logic [31:0] old_action_mask;
    logic        wake_request;
    logic [31:0] mask_value;
    logic [31:0] frame_mask;
    logic [31:0] restorer_out;
    logic [31:0] handler_out;
    logic [5:0]  delivered_sig;
    disp_e       disposition;
    status_e     status;
  } out_item_t;

  typedef struct packed {
    logic        nomask;
    logic        oneshot;
    logic [31:0] extra_mask;
    logic [31:0] restorer;
    logic [31:0] handler;
  } action_t;

  localparam int InTdataW  = 144;
  localparam int OutTdataW = 176;
  localparam int OutPadW   = OutTdataW - $bits(out_item_t);

endpackage

/* hw/rtl/spmd_action_table.sv */
// Per-signal action table with one valid bit per entry; an unwritten entry reads as default.
module spmd_action_table #(
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [$clog2(Depth)-1:0] rd_idx_i,
  output spmd_pkg::action_t        rd_entry_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_idx_i,
  input  spmd_pkg::action_t        wr_entry_i
);
  import spmd_pkg::*;

  action_t              entry_q [Depth];
  logic    [Depth-1:0]  valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_idx_i] <= wr_entry_i;
    end
  end

  assign rd_entry_o = valid_q[rd_idx_i] ? entry_q[rd_idx_i] : '0;

endmodule

/* hw/rtl/signal_pending_mask_delivery.sv */
// Signal delivery controller top level: input register, state update, result register.
// One transfer is taken per clock in steady state while the sink accepts results; each
// item waits in the input register and is resolved against the pending, blocked and
// action state in the cycle it leaves it (lowest eligible signal, one action-table read
// and at most one write); its result is presented from the result register the next
// cycle. The input side keeps taking transfers while a result waits for the sink,
// until both registers are full.
module signal_pending_mask_delivery #(
  parameter int NUM_SIGNALS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // sig_num, new_mask, handler_addr, restorer_addr, action_mask, oneshot_flag,
  // nomask_flag, target_protected, target_waiting, zero pad
  input  logic [spmd_pkg::InTdataW-1:0] s_axis_tdata_i,
  // op
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status, disposition, delivered_sig, handler_out, restorer_out, frame_mask,
  // mask_value, wake_request, old_action_mask, old_oneshot, old_nomask, zero pad
  output logic [spmd_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import spmd_pkg::*;

  localparam int IdxW = $clog2(NUM_SIGNALS);

  logic                   in_valid_q;
  in_item_t               item_q;
  op_e                    op_q;
  logic                   out_valid_q;
  out_item_t              res_q;
  out_item_t              res_d;
  logic [NUM_SIGNALS-1:0] pending_q, pending_d;
  logic [31:0]            blocked_q, blocked_d;

  logic                   in_accept;
  logic                   fire;
  logic [5:0]             sig_m1;
  logic [IdxW-1:0]        sig_idx;
  logic                   sig_in_range;
  logic [31:0]            sig_bit;
  logic [NUM_SIGNALS-1:0] pend_bit;
  logic [NUM_SIGNALS-1:0] eligible;
  logic [NUM_SIGNALS-1:0] lowest;
  logic [IdxW-1:0]        dlv_idx;
  logic [5:0]             dlv_sig;
  logic [IdxW-1:0]        rd_idx;
  action_t                rd_entry;
  action_t                wr_entry;
  logic                   tbl_we;

  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;

  assign sig_m1       = item_q.sig_num - 6'd1;
  assign sig_idx      = sig_m1[IdxW-1:0];
  assign sig_in_range = (item_q.sig_num != 6'd0) && (item_q.sig_num <= 6'(NUM_SIGNALS));
  assign sig_bit      = 32'd1 << sig_m1[4:0];
  assign pend_bit     = NUM_SIGNALS'(1) << sig_idx;

  assign eligible = pending_q & ~blocked_q[NUM_SIGNALS-1:0];
  assign lowest   = eligible & (~eligible + NUM_SIGNALS'(1));

  always_comb begin
    dlv_idx = '0;
    for (int i = 0; i < NUM_SIGNALS; i++) begin
      if (lowest[i]) begin
        dlv_idx = dlv_idx | IdxW'(i);
      end
    end
  end

  assign dlv_sig = 6'(dlv_idx) + 6'd1;
  assign rd_idx  = (op_q == OpDeliver) ? dlv_idx : sig_idx;

  spmd_action_table #(
    .Depth (NUM_SIGNALS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry),
    .wr_en_i    (fire && tbl_we),
    .wr_idx_i   (rd_idx),
    .wr_entry_i (wr_entry)
  );

  always_comb begin
    res_d             = '0;
    res_d.status      = StOk;
    res_d.disposition = DispNotDeliver;
    res_d.mask_value  = blocked_q;
    pending_d         = pending_q;
    blocked_d         = blocked_q;
    tbl_we            = 1'b0;
    wr_entry          = rd_entry;
    case (op_q)
      OpRaise: begin
        if (!sig_in_range) begin
          res_d.status = StInvalid;
        end else if (item_q.target_protected) begin
          res_d.status = StProtected;
        end else begin
          pending_d          = pending_q | pend_bit;
          res_d.wake_request = item_q.target_waiting;
        end
      end
      OpSetMask: begin
        if (item_q.new_mask == '1) begin
          res_d.status = StMaskDenied;
        end else begin
          blocked_d = item_q.new_mask & ~KillMask;
        end
      end
      OpRegister: begin
        if (!sig_in_range || item_q.sig_num == SigKill) begin
          res_d.status = StInvalid;
        end else begin
          res_d.handler_out     = rd_entry.handler;
          res_d.restorer_out    = rd_entry.restorer;
          res_d.old_action_mask = rd_entry.extra_mask;
          res_d.old_oneshot     = rd_entry.oneshot;
          res_d.old_nomask      = rd_entry.nomask;
          tbl_we                = 1'b1;
          wr_entry.handler      = item_q.handler_addr;
          wr_entry.restorer     = item_q.restorer_addr;
          wr_entry.oneshot      = item_q.oneshot_flag;
          wr_entry.nomask       = item_q.nomask_flag;
          wr_entry.extra_mask   = item_q.nomask_flag ? 32'd0
                                                     : (item_q.action_mask | sig_bit);
        end
      end
      OpDeliver: begin
        if (eligible == '0) begin
          res_d.disposition = DispNone;
        end else begin
          res_d.delivered_sig = dlv_sig;
          pending_d           = pending_q & ~lowest;
          if (rd_entry.handler == HandlerIgnore) begin
            res_d.disposition = DispIgnored;
          end else if (rd_entry.handler == HandlerDefault && dlv_sig == SigChild) begin
            res_d.disposition = DispChildDefault;
          end else if (rd_entry.handler == HandlerDefault) begin
            res_d.disposition = DispTerminate;
          end else begin
            res_d.disposition  = DispRunHandler;
            res_d.handler_out  = rd_entry.handler;
            res_d.restorer_out = rd_entry.restorer;
            res_d.frame_mask   = rd_entry.nomask ? blocked_q : '1;
            blocked_d          = (blocked_q | rd_entry.extra_mask) & ~KillMask;
            res_d.mask_value   = (blocked_q | rd_entry.extra_mask) & ~KillMask;
            // oneshot: revert to default handler
            tbl_we             = rd_entry.oneshot;
            wr_entry.handler   = HandlerDefault;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pending_q   <= '0;
      blocked_q   <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        pending_q   <= pending_d;
        blocked_q   <= blocked_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item_t'(s_axis_tdata_i[$bits(in_item_t)-1:0]);
      op_q   <= op_e'(s_axis_tuser_i);
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OutPadW{1'b0}}, res_q};

endmodule

/* hw/rtl/spmd_checker.sv */
// Port-level checks for the signal delivery controller, bound to its top level.
module spmd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [spmd_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import spmd_pkg::*;

  out_item_t res;
  logic      out_xfer;

  assign res      = out_item_t'(m_axis_tdata_o[$bits(out_item_t)-1:0]);
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_deliver_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && res.disposition != DispNotDeliver |-> res.status == StOk)
    else $error("deliver result with non-ok status");

  a_no_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && (res.disposition == DispNone || res.disposition == DispNotDeliver)
      |-> res.delivered_sig == 6'd0)
    else $error("signal number without a delivery");

  a_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && res.wake_request
      |-> res.status == StOk && res.disposition == DispNotDeliver)
    else $error("wake request outside an accepted raise");

endmodule

bind signal_pending_mask_delivery spmd_checker u_spmd_checker (.*);
